>>> sv/multichannel_window_fir_assert.svh
// Assertion macros for the multichannel window FIR.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef MULTICHANNEL_WINDOW_FIR_ASSERT_SVH
`define MULTICHANNEL_WINDOW_FIR_ASSERT_SVH
`ifndef SYNTHESIS
`define MWF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MWF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MWF_ASSERT_IMPL(lbl, ante, cons)
`define MWF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> sv/mwfir_pkg.sv
// Shared types and constants of the multichannel window FIR.
// No dependencies.
package mwfir_pkg;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned TAP_IDX_W   = 8;
  localparam int unsigned TAP_VAL_W   = 15;
  localparam int unsigned CHAN_W      = 3;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned RESULT_W    = 32;
  localparam int unsigned TAP_CNT_W   = 9;
  localparam int unsigned PROD_W      = 32;
  localparam int unsigned FRAC_BITS   = 14;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } fsm_e;

  // Control that travels with each memory read into the MAC.
  typedef struct packed {
    logic start;  // clear the accumulator
    logic valid;  // a read was issued this cycle
    logic ok;     // history word holds a sample of the current record
    logic last;   // final tap of the sum
  } mac_ctl_t;

endpackage

>>> sv/mwfir_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the coefficient and history stores; no dependencies.
module mwfir_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/mwfir_mac.sv
// Multiply-accumulate unit: one tap times one history word per cycle,
// then floor shift and 32-bit saturation. Depends on mwfir_pkg.
module mwfir_mac
  import mwfir_pkg::*;
#(
  parameter int unsigned MAX_TAPS = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mac_ctl_t                   ctl_i,
  input  logic [TAP_VAL_W-1:0]       tap_i,
  input  logic signed [SAMPLE_W-1:0] hist_i,
  output logic                       done_o,
  output logic [RESULT_W-1:0]        result_o
);

  localparam int unsigned TAP_W = $clog2(MAX_TAPS);
  localparam int unsigned ACC_W = PROD_W + TAP_W + 1;

  mac_ctl_t                  ctl_q;
  logic signed [PROD_W-1:0]  prod_raw;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic                      pvalid_q, plast_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic                      done_q;
  logic signed [ACC_W-1:0]   shifted;
  logic [ACC_W-RESULT_W:0]   upper;

  // Align the control with the registered memory data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q    <= '0;
      pvalid_q <= 1'b0;
      plast_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      ctl_q    <= ctl_i;
      pvalid_q <= ctl_q.valid;
      plast_q  <= ctl_q.valid & ctl_q.last;
      done_q   <= pvalid_q & plast_q;
    end
  end

  // Keep the product in a signed context of its own.
  assign prod_raw = $signed({1'b0, tap_i}) * hist_i;

  // Drop words outside the current record: they count as zero.
  assign prod_d = ctl_q.ok ? prod_raw : '0;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      acc_q <= '0;
    end else if (pvalid_q) begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  assign shifted = acc_q >>> FRAC_BITS;
  assign upper   = shifted[ACC_W-1:RESULT_W-1];

  always_comb begin
    if (upper == '0 || upper == '1) begin
      result_o = shifted[RESULT_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      result_o = {1'b1, {(RESULT_W-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(RESULT_W-1){1'b1}}};
    end
  end

  assign done_o = done_q;

endmodule

>>> sv/multichannel_window_fir.sv
// Multichannel window FIR top level: command decode, sequencer and stores.
// Depends on mwfir_pkg, mwfir_ram, mwfir_mac and the assertion header.
//
// A sample request runs one shared multiply-accumulate over the taps in use:
// the coefficient memory and the channel's history memory are each read once
// per cycle, and the sum passes through the memory read registers, the MAC's
// product register and accumulator and the DRAIN and EMIT states into the
// output register. The next request is taken once the result has gone into
// the output register (a stalled output holds the sequencer until the old
// result leaves). Load and clear requests are done on acceptance and give no
// result. After reset the coefficient memory is zeroed, one entry per cycle,
// from entry 0 up to MAX_TAPS - 1; no request is accepted meanwhile (the tap
// count register can still be written). A clear costs no sweep: each channel
// keeps a fill count, and history words older than it read as zero.
`include "multichannel_window_fir_assert.svh"
module multichannel_window_fir
  import mwfir_pkg::*;
#(
  parameter int unsigned MAX_TAPS     = 256,
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [CMD_W-1:0]           cmd_i,
  input  logic [TAP_IDX_W-1:0]       tap_index_i,
  input  logic [TAP_VAL_W-1:0]       tap_value_i,
  input  logic [CHAN_W-1:0]          channel_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [RESULT_W-1:0] filtered_o,
  output logic [CHAN_W-1:0]          out_channel_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [TAP_CNT_W-1:0]       cfg_tap_count_i
);

  localparam int unsigned TAP_W   = $clog2(MAX_TAPS);
  localparam int unsigned CNT_W   = $clog2(MAX_TAPS + 1);
  localparam int unsigned CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned HDEPTH  = (2 ** CH_W) * (2 ** TAP_W);

  fsm_e                  state_q, state_d;
  logic [TAP_CNT_W-1:0]  tap_count_q;
  logic [TAP_W-1:0]      init_cnt_q;
  logic [TAP_W-1:0]      k_q, pos_q, pos_dec;
  logic [CNT_W-1:0]      n_q, fill_q, n_d;
  logic [CH_W-1:0]       ch_q, ch_idx;
  logic [TAP_W-1:0]      ptr_q  [MAX_CHANNELS];
  logic [CNT_W-1:0]      cfill_q [MAX_CHANNELS];
  logic [TAP_W-1:0]      ptr_cur;
  logic [CNT_W-1:0]      fill_cur, fill_new;
  logic                  out_valid_q;
  logic [RESULT_W-1:0]   filtered_q;
  logic [CHAN_W-1:0]     out_channel_q;

  logic                  accept, ch_ok, idx_ok, is_sample, k_last, init_last, out_free;
  logic                  tap_we, hist_we, out_load;
  logic [TAP_W-1:0]      tap_waddr;
  logic [TAP_VAL_W-1:0]  tap_wdata, tap_rdata;
  logic [SAMPLE_W-1:0]   hist_rdata;
  mac_ctl_t              mac_ctl;
  logic                  mac_done;
  logic [RESULT_W-1:0]   mac_result;

  assign accept    = in_valid_i & ~in_stall_o;
  assign ch_ok     = 32'(channel_i) < MAX_CHANNELS;
  assign idx_ok    = 32'(tap_index_i) < MAX_TAPS;
  assign ch_idx    = CH_W'(channel_i);
  assign is_sample = accept & (cmd_i == CMD_SAMPLE) & ch_ok;
  assign k_last    = (CNT_W'(k_q) == n_q - 1'b1);
  assign init_last = (init_cnt_q == TAP_W'(MAX_TAPS - 1));
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign pos_dec   = (pos_q == '0) ? TAP_W'(MAX_TAPS - 1) : pos_q - 1'b1;

  assign ptr_cur  = ch_ok ? ptr_q[ch_idx] : '0;
  assign fill_cur = ch_ok ? cfill_q[ch_idx] : '0;
  assign fill_new = (fill_cur == CNT_W'(MAX_TAPS)) ? fill_cur : fill_cur + 1'b1;

  // Clamp the tap count into 1..MAX_TAPS.
  always_comb begin
    if (tap_count_q == '0) begin
      n_d = CNT_W'(1);
    end else if (32'(tap_count_q) > MAX_TAPS) begin
      n_d = CNT_W'(MAX_TAPS);
    end else begin
      n_d = CNT_W'(tap_count_q);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT:  if (init_last) state_d = ST_IDLE;
      ST_IDLE:  if (is_sample) state_d = ST_RUN;
      ST_RUN:   if (k_last) state_d = ST_DRAIN;
      ST_DRAIN: if (mac_done) state_d = ST_EMIT;
      ST_EMIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_INIT;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall_o = 1'b1;
    tap_we     = 1'b0;
    tap_waddr  = TAP_W'(tap_index_i);
    tap_wdata  = tap_value_i;
    hist_we    = 1'b0;
    mac_ctl    = '0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        tap_we    = 1'b1;
        tap_waddr = init_cnt_q;
        tap_wdata = '0;
      end
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        tap_we        = accept & (cmd_i == CMD_LOAD) & idx_ok;
        hist_we       = is_sample;
        mac_ctl.start = is_sample;
      end
      ST_RUN: begin
        mac_ctl.valid = 1'b1;
        mac_ctl.ok    = CNT_W'(k_q) < fill_q;
        mac_ctl.last  = k_last;
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      tap_count_q <= TAP_CNT_W'(1);
      init_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        ptr_q[i]   <= '0;
        cfill_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        tap_count_q <= cfg_tap_count_i;
      end
      if (state_q == ST_INIT) begin
        init_cnt_q <= init_cnt_q + 1'b1;
      end
      if (accept && cmd_i == CMD_CLEAR) begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
          ptr_q[i]   <= '0;
          cfill_q[i] <= '0;
        end
      end else if (is_sample) begin
        ptr_q[ch_idx]   <= (ptr_cur == TAP_W'(MAX_TAPS - 1)) ? '0 : ptr_cur + 1'b1;
        cfill_q[ch_idx] <= fill_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-sample working registers.
  always_ff @(posedge clk_i) begin
    if (is_sample) begin
      ch_q   <= ch_idx;
      pos_q  <= ptr_cur;
      k_q    <= '0;
      n_q    <= n_d;
      fill_q <= fill_new;
    end else if (state_q == ST_RUN) begin
      pos_q <= pos_dec;
      k_q   <= k_q + 1'b1;
    end
    if (out_load) begin
      filtered_q    <= mac_result;
      out_channel_q <= CHAN_W'(ch_q);
    end
  end

  mwfir_ram #(
    .WIDTH (TAP_VAL_W),
    .DEPTH (2 ** TAP_W)
  ) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .waddr_i (tap_waddr),
    .wdata_i (tap_wdata),
    .raddr_i (k_q),
    .rdata_o (tap_rdata)
  );

  mwfir_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (HDEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i ({ch_idx, ptr_cur}),
    .wdata_i (sample_i),
    .raddr_i ({ch_q, pos_q}),
    .rdata_o (hist_rdata)
  );

  mwfir_mac #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .tap_i    (tap_rdata),
    .hist_i   ($signed(hist_rdata)),
    .done_o   (mac_done),
    .result_o (mac_result)
  );

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign filtered_o    = $signed(filtered_q);
  assign out_channel_o = out_channel_q;

  `MWF_ASSERT_NEXT(a_sample_starts_run, is_sample, state_q == ST_RUN)
  `MWF_ASSERT_IMPL(a_done_in_drain, mac_done, state_q == ST_DRAIN)
  `MWF_ASSERT_IMPL(a_k_in_range, state_q == ST_RUN, CNT_W'(k_q) < n_q)
  `MWF_ASSERT_IMPL(a_out_from_emit, $rose(out_valid_q), $past(state_q) == ST_EMIT)

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for multichannel_window_fir: a directed table, then random phases
// over several tap counts, checked against a behavioral FIR with its own tap and history stores.
// Depends on mwfir_pkg and the multichannel_window_fir RTL.
module tb_top;
  import mwfir_pkg::*;

  localparam int unsigned MAX_TAPS     = 256;
  localparam int unsigned MAX_CHANNELS = 8;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int MAX_WAIT      = 14;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = MAX_TAPS + 40;
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam int N_PHASES = 9;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [TAP_IDX_W-1:0] tap_index;
    logic [TAP_VAL_W-1:0] tap_value;
    logic [CHAN_W-1:0]    channel;
    logic [SAMPLE_W-1:0]  sample;
  } fir_request_t;

  typedef struct packed {
    logic [RESULT_W-1:0] filtered;
    logic [CHAN_W-1:0]   channel;
  } fir_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    fir_request_t        req;
    logic [TAP_CNT_W-1:0] tap_count;
    logic                typed;
    logic [RESULT_W-1:0] want;
  } plan_row_t;

  // Random phases: tap count range, item count, highest channel, clears allowed.
  int phase_tap_lo [N_PHASES] = '{8, 1, 256, 511, 0, 300, 3, 32, 1};
  int phase_tap_hi [N_PHASES] = '{8, 1, 256, 511, 0, 300, 3, 32, 48};
  int phase_items  [N_PHASES] = '{230, 420, 60, 40, 100, 40, 250, 220, 160};
  int phase_ch_hi  [N_PHASES] = '{7, 0, 1, 7, 7, 7, 7, 3, 7};
  bit phase_clear  [N_PHASES] = '{1, 0, 0, 0, 1, 1, 1, 1, 1};

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 in_valid_i      = 1'b0;
  logic [CMD_W-1:0]     cmd_i           = '0;
  logic [TAP_IDX_W-1:0] tap_index_i     = '0;
  logic [TAP_VAL_W-1:0] tap_value_i     = '0;
  logic [CHAN_W-1:0]    channel_i       = '0;
  logic signed [SAMPLE_W-1:0] sample_i  = '0;
  logic                 out_stall_i     = 1'b1;
  logic                 cfg_valid_i     = 1'b0;
  logic [TAP_CNT_W-1:0] cfg_tap_count_i = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic signed [RESULT_W-1:0] filtered_o;
  logic [CHAN_W-1:0]    out_channel_o;
  logic                 cfg_ready_o;

  multichannel_window_fir #(
    .MAX_TAPS    (MAX_TAPS),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .tap_index_i    (tap_index_i),
    .tap_value_i    (tap_value_i),
    .channel_i      (channel_i),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .filtered_o     (filtered_o),
    .out_channel_o  (out_channel_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_tap_count_i(cfg_tap_count_i)
  );

  always #5 clk_i = ~clk_i;

  // Behavioral FIR state.
  logic [TAP_VAL_W-1:0]       coef_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] hist_mem [MAX_CHANNELS][MAX_TAPS];
  logic [7:0]                 next_slot [MAX_CHANNELS];
  logic [TAP_CNT_W-1:0]       tap_count_q;

  fir_result_t pending_results[$];
  int mismatches = 0;
  int idle_run [2] = '{0, 0};
  longint cycle_count = 0;

  function automatic void clear_histories();
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      next_slot[c] = '0;
      for (int k = 0; k < MAX_TAPS; k++) hist_mem[c][k] = '0;
    end
  endfunction

  // Apply one request to the behavioral state; return 1 when it yields a filtered sample.
  function automatic bit fir_predict(input fir_request_t r, output fir_result_t res);
    longint acc;
    longint q;
    int n;
    logic [7:0] pos;
    res = '0;
    fir_predict = 1'b0;
    case (r.cmd)
      CMD_LOAD: coef_mem[r.tap_index] = r.tap_value;
      CMD_CLEAR: clear_histories();
      CMD_SAMPLE: begin
        pos = next_slot[r.channel];
        hist_mem[r.channel][pos] = r.sample;
        next_slot[r.channel] = pos + 8'd1;
        n = (tap_count_q == 0) ? 1 : (tap_count_q > MAX_TAPS) ? MAX_TAPS : int'(tap_count_q);
        acc = 0;
        for (int k = 0; k < n; k++) begin
          acc += longint'(coef_mem[k]) * longint'(hist_mem[r.channel][pos]);
          pos = pos - 8'd1;
        end
        q = acc >>> FRAC_BITS;
        if (q > SAT_HI) q = SAT_HI;
        if (q < SAT_LO) q = SAT_LO;
        res.filtered = q[RESULT_W-1:0];
        res.channel  = r.channel;
        fir_predict  = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Idle draw per side (0 sender, 1 receiver), with stretches of back-to-back traffic.
  function automatic int draw_wait(input int side);
    if (idle_run[side] > 0) begin
      idle_run[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      idle_run[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic plan_row_t plan_row(input row_kind_e kind, input logic [CMD_W-1:0] cmd,
                                         input int idx, input int val, input int ch,
                                         input int smp, input bit typed, input int want);
    plan_row_t p;
    p.kind          = kind;
    p.req.cmd       = cmd;
    p.req.tap_index = idx[TAP_IDX_W-1:0];
    p.req.tap_value = val[TAP_VAL_W-1:0];
    p.req.channel   = ch[CHAN_W-1:0];
    p.req.sample    = smp[SAMPLE_W-1:0];
    // a configuration row carries the tap count in val
    p.tap_count     = val[TAP_CNT_W-1:0];
    p.typed         = typed;
    p.want          = want;
    return p;
  endfunction

  function automatic fir_request_t random_request(input int ch_hi, input bit clear_ok);
    fir_request_t r;
    int pick;
    r.tap_index = TAP_IDX_W'($urandom_range(0, 1) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: r.tap_value = '0;
      1: r.tap_value = 15'd16384;
      2: r.tap_value = 15'h7FFF;
      default: r.tap_value = TAP_VAL_W'($urandom_range(0, 32767));
    endcase
    r.channel = CHAN_W'($urandom_range(0, ch_hi));
    if ($urandom_range(0, 7) == 0) r.sample = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    else r.sample = SAMPLE_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 74) r.cmd = CMD_SAMPLE;
    else if (pick < 90) r.cmd = CMD_LOAD;
    else if (pick < 94) r.cmd = clear_ok ? CMD_CLEAR : CMD_SAMPLE;
    else r.cmd = CMD_UNUSED;
    return r;
  endfunction

  task automatic send_request(input fir_request_t r, input bit typed,
                              input logic [RESULT_W-1:0] typed_val);
    int gap;
    fir_result_t res;
    gap = draw_wait(0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= r.cmd;
    tap_index_i <= r.tap_index;
    tap_value_i <= r.tap_value;
    channel_i   <= r.channel;
    sample_i    <= r.sample;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (fir_predict(r, res)) begin
      if (typed) res.filtered = typed_val;
      pending_results.push_back(res);
    end
  endtask

  // Hold the input side until every expected sample has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_tap_count(input logic [TAP_CNT_W-1:0] value);
    drain_results();
    // loads and clears leave no result behind; let them retire
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_tap_count_i <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    tap_count_q  = value;
  endtask

  initial begin : result_sink
    int w;
    forever begin
      w = draw_wait(1);
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  always @(posedge clk_i) begin : result_check
    fir_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual filtered %0d channel %0d",
                 $time, filtered_o, out_channel_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (filtered_o !== $signed(want.filtered)) begin
          $display("%0t: filtered mismatch: expected %0d, actual %0d", $time,
                   $signed(want.filtered), filtered_o);
          mismatches++;
        end
        if (out_channel_o !== want.channel) begin
          $display("%0t: out_channel mismatch: expected %0d, actual %0d", $time,
                   want.channel, out_channel_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t plan[$];
    fir_request_t r;
    int done;
    for (int k = 0; k < MAX_TAPS; k++) coef_mem[k] = '0;
    clear_histories();
    tap_count_q = 9'd1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    plan = '{
      // taps all zero after reset
      plan_row(ROW_REQ, CMD_SAMPLE, 0, 0, 0, 32767, 1, 0),
      plan_row(ROW_REQ, CMD_SAMPLE, 0, 0, 7, -32768, 1, 0),
      // unity tap passes the sample through
      plan_row(ROW_REQ, CMD_LOAD, 0, 16384, 0, 0, 0, 0),
      plan_row(ROW_REQ, CMD_SAMPLE, 0, 0, 7, 32767, 1, 32767),
      plan_row(ROW_REQ, CMD_SAMPLE, 0, 0, 3, -32768, 1, -32768),
      // tap above unity uses all 15 bits
      plan_row(ROW_REQ, CMD_LOAD, 0, 32767, 0, 0, 0, 0),
      plan_row(ROW_REQ, CMD_SAMPLE, 0, 0, 0, -32768, 1, -65534),
      plan_row(ROW_REQ, CMD_SAMPLE, 0, 0, 0, 32767, 1, 65532),
      // floor rounding of tiny sums
      plan_row(ROW_REQ, CMD_LOAD, 0, 1, 0, 0, 0, 0),
      plan_row(ROW_REQ, CMD_SAMPLE, 0, 0, 5, -1, 1, -1),
      plan_row(ROW_REQ, CMD_SAMPLE, 0, 0, 5, 1, 1, 0),
      // unused command code gives nothing
      plan_row(ROW_REQ, CMD_UNUSED, 255, 32767, 7, -1, 0, 0),
      plan_row(ROW_REQ, CMD_LOAD, 255, 32767, 0, 0, 0, 0),
      plan_row(ROW_REQ, CMD_LOAD, 1, 16384, 0, 0, 0, 0),
      plan_row(ROW_CFG, CMD_LOAD, 0, 2, 0, 0, 0, 0),
      plan_row(ROW_REQ, CMD_SAMPLE, 0, 0, 5, 100, 0, 0),
      plan_row(ROW_REQ, CMD_CLEAR, 0, 0, 0, 0, 0, 0),
      plan_row(ROW_REQ, CMD_SAMPLE, 0, 0, 5, -32768, 1, -2),
      // zero tap count acts as one tap
      plan_row(ROW_CFG, CMD_LOAD, 0, 0, 0, 0, 0, 0),
      plan_row(ROW_REQ, CMD_SAMPLE, 0, 0, 2, 7, 0, 0),
      // tap count beyond the store acts as the full window
      plan_row(ROW_CFG, CMD_LOAD, 0, 511, 0, 0, 0, 0),
      plan_row(ROW_REQ, CMD_SAMPLE, 0, 0, 5, 5, 0, 0),
      plan_row(ROW_REQ, CMD_SAMPLE, 0, 0, 7, -32768, 0, 0),
      plan_row(ROW_REQ, CMD_CLEAR, 0, 0, 0, 0, 0, 0)
    };
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_tap_count(plan[i].tap_count);
      else send_request(plan[i].req, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_tap_count(TAP_CNT_W'($urandom_range(phase_tap_hi[p], phase_tap_lo[p])));
      done = 0;
      while (done < phase_items[p]) begin
        r = random_request(phase_ch_hi[p], phase_clear[p]);
        if (done == phase_items[p] / 2 || $urandom_range(0, 99) == 0) drain_results();
        send_request(r, 1'b0, '0);
        if (r.cmd != CMD_UNUSED) done++;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
